// ----- design/base64_stream_encoder_macros.svh -----
// Assertion macros shared by the base64 stream encoder modules.
// Expects signals named clk and rst in the module that uses them.
`ifndef BASE64_STREAM_ENCODER_MACROS_SVH
`define BASE64_STREAM_ENCODER_MACROS_SVH

// expression holds at every edge outside reset
`define B64E_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// same-cycle implication
`define B64E_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define B64E_IMPLIES_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/b64e_pkg.sv -----
// Types, constants and the sextet-to-ASCII mapping for the base64 stream encoder.
// No dependencies.
package b64e_pkg;

  localparam int JOB_DEPTH = 2;
  localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
  localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);
  localparam logic [JOB_CNT_W-1:0] JOB_FULL_CNT = JOB_CNT_W'(JOB_DEPTH);

  localparam int SYMS_PER_JOB = 4;
  localparam int SYM_IDX_W = $clog2(SYMS_PER_JOB);
  localparam int SYM_CNT_W = $clog2(SYMS_PER_JOB + 1);

  localparam logic [6:0] PAD_CHAR = 7'h3D;

  typedef enum logic [1:0] {
    PH_BYTE0 = 2'd0,
    PH_BYTE1 = 2'd1,
    PH_BYTE2 = 2'd2
  } phase_t;

  typedef struct packed {
    logic       pad;
    logic [5:0] val;
  } sym_t;

  // One encoded byte: up to four output characters
  typedef struct packed {
    sym_t [SYMS_PER_JOB-1:0] syms;
    logic [SYM_CNT_W-1:0]    cnt;
    logic                    last;
  } job_t;

  function automatic logic [6:0] sym_to_ascii(sym_t s);
    logic [6:0] v;
    v = {1'b0, s.val};
    if (s.pad) return PAD_CHAR;
    else if (s.val < 6'd26) return v + 7'd65;
    else if (s.val < 6'd52) return v + 7'd71;
    else if (s.val < 6'd62) return v - 7'd4;
    else if (s.val == 6'd62) return 7'h2B;
    else return 7'h2F;
  endfunction

endpackage

// ----- design/b64e_front.sv -----
// Front end: accepts bytes, tracks group phase and carry bits, builds jobs.
// Depends on b64e_pkg.
module b64e_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic          q_full,
  input  logic [7:0]    data_byte,
  input  logic          last_byte,
  output logic          job_push,
  output b64e_pkg::job_t job
);
  import b64e_pkg::*;

  phase_t     phase, phase_next;
  logic [3:0] carry_bits, carry_bits_next;

  assign job_push = push && !q_full;

  always_comb begin
    phase_next      = phase;
    carry_bits_next = carry_bits;
    if (job_push) begin
      if (last_byte) begin
        phase_next      = PH_BYTE0;
        carry_bits_next = 4'd0;
      end else begin
        unique case (phase)
          PH_BYTE1: begin
            phase_next      = PH_BYTE2;
            carry_bits_next = data_byte[3:0];
          end
          PH_BYTE2: begin
            phase_next      = PH_BYTE0;
            carry_bits_next = 4'd0;
          end
          default: begin
            phase_next      = PH_BYTE1;
            carry_bits_next = {2'b00, data_byte[1:0]};
          end
        endcase
      end
    end
  end

  always_comb begin
    job      = '0;
    job.last = last_byte;
    unique case (phase)
      PH_BYTE1: begin
        job.syms[0] = '{pad: 1'b0, val: {carry_bits[1:0], data_byte[7:4]}};
        if (last_byte) begin
          job.syms[1] = '{pad: 1'b0, val: {data_byte[3:0], 2'b00}};
          job.syms[2] = '{pad: 1'b1, val: 6'd0};
          job.cnt     = SYM_CNT_W'(3);
        end else begin
          job.cnt = SYM_CNT_W'(1);
        end
      end
      PH_BYTE2: begin
        job.syms[0] = '{pad: 1'b0, val: {carry_bits, data_byte[7:6]}};
        job.syms[1] = '{pad: 1'b0, val: data_byte[5:0]};
        job.cnt     = SYM_CNT_W'(2);
      end
      default: begin
        job.syms[0] = '{pad: 1'b0, val: data_byte[7:2]};
        if (last_byte) begin
          job.syms[1] = '{pad: 1'b0, val: {data_byte[1:0], 4'b0000}};
          job.syms[2] = '{pad: 1'b1, val: 6'd0};
          job.syms[3] = '{pad: 1'b1, val: 6'd0};
          job.cnt     = SYM_CNT_W'(4);
        end else begin
          job.cnt = SYM_CNT_W'(1);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_BYTE0;
      carry_bits <= 4'd0;
    end else begin
      phase      <= phase_next;
      carry_bits <= carry_bits_next;
    end
  end

endmodule

// ----- design/b64e_job_fifo.sv -----
// Short job queue between front and back ends.
// Depends on b64e_pkg and base64_stream_encoder_macros.svh.
`include "base64_stream_encoder_macros.svh"

module b64e_job_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  b64e_pkg::job_t wr_job,
  input  logic           rd_en,
  output logic           full,
  output logic           head_valid,
  output b64e_pkg::job_t head
);
  import b64e_pkg::*;

  job_t                 entries [JOB_DEPTH];
  logic [JOB_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [JOB_CNT_W-1:0] cnt;

  assign full       = (cnt == JOB_FULL_CNT);
  assign head_valid = (cnt != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) entries[wr_ptr] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (wr_en) wr_ptr <= (wr_ptr == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (rd_en) rd_ptr <= (rd_ptr == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (wr_en && !rd_en) cnt <= cnt + 1'b1;
      else if (rd_en && !wr_en) cnt <= cnt - 1'b1;
    end
  end

  `B64E_ALWAYS(a_cnt_range, cnt <= JOB_FULL_CNT, "job queue count out of range")
  `B64E_IMPLIES(a_no_overflow, wr_en && !rd_en, !full, "job queue overflow")
  `B64E_IMPLIES(a_no_underflow, rd_en, head_valid, "job queue underflow")

endmodule

// ----- design/b64e_back.sv -----
// Back end: walks each job one character per cycle into the output register while that register is empty or popped.
// Depends on b64e_pkg and base64_stream_encoder_macros.svh.
`include "base64_stream_encoder_macros.svh"

module b64e_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  b64e_pkg::job_t head,
  output logic           deq,
  input  logic           pop,
  output logic           empty,
  output logic [6:0]     ascii_char,
  output logic           last_char
);
  import b64e_pkg::*;

  logic [SYM_IDX_W-1:0] sym_idx, sym_idx_next;
  logic                 out_valid, out_valid_next;
  logic                 out_load, final_sym;
  sym_t                 cur_sym;

  assign cur_sym   = head.syms[sym_idx];
  assign final_sym = (SYM_CNT_W'(sym_idx) == head.cnt - 1'b1);
  assign out_load  = head_valid && (!out_valid || pop);
  assign deq       = out_load && final_sym;
  assign empty     = !out_valid;

  always_comb begin
    sym_idx_next   = sym_idx;
    out_valid_next = out_valid && !pop;
    if (out_load) begin
      out_valid_next = 1'b1;
      sym_idx_next   = final_sym ? '0 : sym_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      ascii_char <= sym_to_ascii(cur_sym);
      last_char  <= final_sym && head.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sym_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      sym_idx   <= sym_idx_next;
      out_valid <= out_valid_next;
    end
  end

  `B64E_IMPLIES(a_idx_in_job, head_valid, SYM_CNT_W'(sym_idx) < head.cnt, "symbol index past job")
  `B64E_IMPLIES_NEXT(a_restart, deq, sym_idx == '0, "symbol index not rewound")

endmodule

// ----- design/base64_stream_encoder.sv -----
// Base64 stream encoder: one byte per transaction in, one character per transaction out.
// The first character of a byte is registered in the job queue, then in the output register.
// Throughput: one character per cycle from the output register while the receiver pops;
// a byte yields 1 to 4 characters, which the back end serializes from each job.
// Reset (rst, synchronous): group phase and carry cleared, job queue and output emptied.
module base64_stream_encoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       empty,
  input  logic       pop,
  output logic [6:0] ascii_char,
  output logic       last_char
);
  import b64e_pkg::*;

  job_t new_job, head;
  logic job_push, head_valid, deq;

  b64e_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .q_full    (full),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .job_push  (job_push),
    .job       (new_job)
  );

  b64e_job_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (job_push),
    .wr_job     (new_job),
    .rd_en      (deq),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  b64e_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .deq        (deq),
    .pop        (pop),
    .empty      (empty),
    .ascii_char (ascii_char),
    .last_char  (last_char)
  );

endmodule

// ----- dv/b64_stream_checker.sv -----
`timescale 1ns / 100ps
// Checker for the base64 stream encoder: predicts the characters of each accepted byte
// and compares every accepted output character in order. Depends on b64e_pkg.
module b64_stream_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       full,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  logic       empty,
  input  logic       pop,
  input  logic [6:0] ascii_char,
  input  logic       last_char,
  output int         errors,
  output int         outstanding
);
  import b64e_pkg::*;

  localparam logic [8*64-1:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct {
    logic [6:0] code;
    logic       fin;
  } enc_char_t;

  enc_char_t  expected_chars[$];
  phase_t     group_pos;
  logic [3:0] leftover;

  initial begin
    errors      = 0;
    outstanding = 0;
    group_pos   = PH_BYTE0;
    leftover    = '0;
  end

  function automatic logic [6:0] sextet_ascii(input logic [5:0] v);
    return ALPHABET[(63 - int'(v)) * 8 +: 7];
  endfunction

  function automatic void add_char(input logic [6:0] code, input logic fin);
    enc_char_t c;
    c.code = code;
    c.fin  = fin;
    expected_chars.push_back(c);
  endfunction

  function automatic void encode_byte(input logic [7:0] b, input logic fin);
    case (group_pos)
      PH_BYTE1: begin
        add_char(sextet_ascii({leftover[1:0], b[7:4]}), 1'b0);
        if (fin) begin
          add_char(sextet_ascii({b[3:0], 2'b00}), 1'b0);
          add_char(PAD_CHAR, 1'b1);
        end else begin
          leftover  = b[3:0];
          group_pos = PH_BYTE2;
        end
      end
      PH_BYTE2: begin
        add_char(sextet_ascii({leftover, b[7:6]}), 1'b0);
        add_char(sextet_ascii(b[5:0]), fin);
        leftover  = '0;
        group_pos = PH_BYTE0;
      end
      default: begin
        add_char(sextet_ascii(b[7:2]), 1'b0);
        if (fin) begin
          add_char(sextet_ascii({b[1:0], 4'b0000}), 1'b0);
          add_char(PAD_CHAR, 1'b0);
          add_char(PAD_CHAR, 1'b1);
        end else begin
          leftover  = {2'b00, b[1:0]};
          group_pos = PH_BYTE1;
        end
      end
    endcase
    // end of buffer: back to the start of a group
    if (fin) begin
      group_pos = PH_BYTE0;
      leftover  = '0;
    end
  endfunction

  task automatic report(input string msg);
    $display("%0t ns: mismatch: %s", $realtime, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    enc_char_t exp_c;
    if (rst) begin
      expected_chars.delete();
      group_pos = PH_BYTE0;
      leftover  = '0;
    end else begin
      if (push && !full) encode_byte(data_byte, last_byte);
      if (pop && !empty) begin
        if (expected_chars.size() == 0) begin
          report($sformatf("unexpected char 0x%02h last_char %0b", ascii_char, last_char));
        end else begin
          exp_c = expected_chars.pop_front();
          if (ascii_char !== exp_c.code)
            report($sformatf("ascii_char 0x%02h, expected 0x%02h", ascii_char, exp_c.code));
          if (last_char !== exp_c.fin)
            report($sformatf("last_char %0b, expected %0b (char 0x%02h)",
                             last_char, exp_c.fin, exp_c.code));
        end
      end
    end
    outstanding <= expected_chars.size();
  end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the base64 stream encoder: drives bytes and pops characters under
// several idle/stall mixes. Depends on base64_stream_encoder and b64_stream_checker.
module tb;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam int RANDOM_PER_MIX = 84;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] data_byte = '0;
  logic       last_byte = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [6:0] ascii_char;
  logic       last_char;

  int errors;
  int outstanding;
  int idle_pct  = 0;
  int stall_pct = 0;
  int hold_count = 0;
  int quiet_cycles = 0;
  bit hold_req = 1'b0;
  bit hold_ack = 1'b0;

  // {last_byte, data_byte}
  logic [8:0] directed_items [0:24] = '{
    9'h100, 9'h1FF,
    9'h000, 9'h100,
    9'h0FF, 9'h1FF,
    9'h000, 9'h000, 9'h100,
    9'h0FF, 9'h0FF, 9'h1FF,
    9'h0FB, 9'h0EF, 9'h1BE,
    9'h066, 9'h06F, 9'h06F, 9'h062, 9'h061, 9'h172,
    9'h064, 9'h068, 9'h1D0,
    9'h1F4
  };

  always #1 clk = ~clk;

  base64_stream_encoder DUT (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .empty      (empty),
    .pop        (pop),
    .ascii_char (ascii_char),
    .last_char  (last_char)
  );

  b64_stream_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .data_byte   (data_byte),
    .last_byte   (last_byte),
    .empty       (empty),
    .pop         (pop),
    .ascii_char  (ascii_char),
    .last_char   (last_char),
    .errors      (errors),
    .outstanding (outstanding)
  );

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      pop <= 1'b0;
      if (hold_count == HOLD_CYCLES) begin
        hold_ack   <= hold_req;
        hold_count <= 0;
      end else begin
        hold_count <= hold_count + 1;
      end
    end else begin
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push      <= 1'b1;
    data_byte <= b;
    last_byte <= fin;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic send_random_bytes(input int count);
    logic [7:0] b;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(7))
        0:       b = 8'h00;
        1:       b = 8'hFF;
        default: b = 8'($urandom_range(255));
      endcase
      send_byte(b, $urandom_range(4) == 0);
    end
  endtask

  // watchdog: ends the run when no transaction happens for too long
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_items[i]) send_byte(directed_items[i][7:0], directed_items[i][8]);
    wait_drained();

    // no idling, with a long receiver hold-off at the start
    hold_req <= ~hold_req;
    send_random_bytes(RANDOM_PER_MIX);
    wait_drained();

    idle_pct  = 87;
    stall_pct = 0;
    send_random_bytes(RANDOM_PER_MIX);

    idle_pct  = 0;
    stall_pct = 87;
    send_random_bytes(RANDOM_PER_MIX);

    idle_pct  = 37;
    stall_pct = 37;
    send_random_bytes(RANDOM_PER_MIX);
    send_byte(8'($urandom_range(255)), 1'b1);

    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
